[rtl/ovl_pkg.sv]
// Package for the ordered value list engine.
// It holds the operation kinds, the status codes and the default capacity.
// It has no dependencies.
`default_nettype none

package ovl_pkg;

    localparam int CAPACITY_DEF = 64;

    // Widths of the beat fields.
    localparam int KIND_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int PLACE_W  = 7;
    localparam int STATUS_W = 2;
    localparam int WHERE_W  = 7;
    localparam int COUNT_W  = 7;

    // Operation kinds.
    localparam logic [KIND_W-1:0] K_FRONT    = 4'd0;
    localparam logic [KIND_W-1:0] K_BACK     = 4'd1;
    localparam logic [KIND_W-1:0] K_ORDERED  = 4'd2;
    localparam logic [KIND_W-1:0] K_AT       = 4'd3;
    localparam logic [KIND_W-1:0] K_RM_FIRST = 4'd4;
    localparam logic [KIND_W-1:0] K_RM_ALL   = 4'd5;
    localparam logic [KIND_W-1:0] K_FIND     = 4'd6;
    localparam logic [KIND_W-1:0] K_CLEAR    = 4'd7;
    localparam logic [KIND_W-1:0] K_TAIL_SUM = 4'd8;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    // Position reported when nothing was found.
    localparam logic [WHERE_W-1:0] NO_INDEX = 7'h7F;

endpackage

`default_nettype wire

[rtl/ovl_ram.sv]
// Value store of the ordered value list engine: one write port and one
// read port with registered read data. Uses ovl_pkg for the value width.
`default_nettype none

module ovl_ram #(
    parameter int CAPACITY = ovl_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [ovl_pkg::VALUE_W-1:0] wdata,
    input  wire logic [AW-1:0]               raddr,
    output logic      [ovl_pkg::VALUE_W-1:0] rdata
);

    logic [ovl_pkg::VALUE_W-1:0] mem [CAPACITY];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/ovl_ctrl.sv]
// Sequencer of the ordered value list engine: scans, shifts, compacts and
// sums the store through its memory port signals, and holds the result register.
// Uses ovl_pkg for kinds, status codes and field widths.
`default_nettype none

module ovl_ctrl #(
    parameter int CAPACITY = ovl_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic        [ovl_pkg::KIND_W-1:0]  kind,
    input  wire logic signed [ovl_pkg::VALUE_W-1:0] value,
    input  wire logic        [ovl_pkg::PLACE_W-1:0] place,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic        [ovl_pkg::STATUS_W-1:0]     status,
    output logic                                    found,
    output logic signed [ovl_pkg::WHERE_W-1:0]      where_found,
    output logic        [ovl_pkg::COUNT_W-1:0]      count,
    output logic signed [ovl_pkg::VALUE_W-1:0]      total,
    output logic                                    mem_we,
    output logic        [AW-1:0]                    mem_waddr,
    output logic        [ovl_pkg::VALUE_W-1:0]      mem_wdata,
    output logic        [AW-1:0]                    mem_raddr,
    input  wire logic   [ovl_pkg::VALUE_W-1:0]      mem_rdata
);

    localparam int CMPW = (CW > ovl_pkg::PLACE_W) ? CW : ovl_pkg::PLACE_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EX, S_UP_RD, S_UP_EX, S_PLACE,
        S_COMP_RD, S_COMP_EX, S_SUM_RD, S_SUM_EX, S_FINISH
    } state_t;

    state_t                          state_reg;
    logic [ovl_pkg::KIND_W-1:0]      kind_reg;
    logic [ovl_pkg::VALUE_W-1:0]     val_reg;
    logic [CW-1:0]                   cnt_reg;
    logic [CW-1:0]                   k_reg;
    logic [CW-1:0]                   j_reg;
    logic [CW-1:0]                   idx_reg;
    logic [ovl_pkg::VALUE_W-1:0]     acc_reg;
    logic [ovl_pkg::STATUS_W-1:0]    st_reg;
    logic                            fnd_reg;
    logic [ovl_pkg::WHERE_W-1:0]     wh_reg;
    logic                            out_valid_reg;

    logic                            in_beat;
    logic                            last_k;
    logic                            place_gt_cnt;
    logic                            keep;

    assign in_ready     = (state_reg == S_IDLE);
    assign in_beat      = in_valid && in_ready;
    assign last_k       = (k_reg == cnt_reg - ONE);
    assign place_gt_cnt = CMPW'(place) > CMPW'(cnt_reg);
    assign keep         = (kind_reg == ovl_pkg::K_RM_FIRST) || (mem_rdata != val_reg);
    assign out_valid    = out_valid_reg;

    // Memory port drive for each step of the sequencer.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = k_reg[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = k_reg[AW-1:0];
        unique case (state_reg)
            S_UP_EX:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(k_reg + ONE);
            end
            S_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = val_reg;
            end
            S_COMP_EX:
            begin
                mem_we    = keep;
                mem_waddr = j_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The finish step handles the result register on its own.
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        kind_reg <= kind;
                        val_reg  <= value;
                        st_reg   <= ovl_pkg::ST_OK;
                        fnd_reg  <= 1'b0;
                        wh_reg   <= ovl_pkg::NO_INDEX;
                        acc_reg  <= '0;
                        k_reg    <= '0;
                        state_reg <= S_FINISH;
                        if (kind <= ovl_pkg::K_AT)
                        begin
                            if (cnt_reg == CAP)
                            begin
                                st_reg <= ovl_pkg::ST_FULL;
                            end
                            else if (kind == ovl_pkg::K_ORDERED)
                            begin
                                idx_reg   <= cnt_reg;
                                state_reg <= (cnt_reg == '0) ? S_PLACE : S_SCAN_RD;
                            end
                            else if (kind == ovl_pkg::K_AT && place_gt_cnt)
                            begin
                                st_reg <= ovl_pkg::ST_RANGE;
                            end
                            else
                            begin
                                // Front, back or a position in range.
                                priority if (kind == ovl_pkg::K_FRONT)
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= (cnt_reg != '0) ? S_UP_RD : S_PLACE;
                                end
                                else if (kind == ovl_pkg::K_BACK)
                                begin
                                    idx_reg   <= cnt_reg;
                                    state_reg <= S_PLACE;
                                end
                                else
                                begin
                                    idx_reg   <= CW'(place);
                                    state_reg <= (cnt_reg > CW'(place)) ? S_UP_RD : S_PLACE;
                                end
                                k_reg <= cnt_reg - ONE;
                            end
                        end
                        else if (kind <= ovl_pkg::K_FIND)
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_reg <= ovl_pkg::ST_ABSENT;
                            end
                            else
                            begin
                                state_reg <= S_SCAN_RD;
                            end
                        end
                        else if (kind == ovl_pkg::K_CLEAR)
                        begin
                            cnt_reg <= '0;
                        end
                        else if (kind == ovl_pkg::K_TAIL_SUM)
                        begin
                            if (place_gt_cnt)
                            begin
                                st_reg <= ovl_pkg::ST_RANGE;
                            end
                            else if (place != '0)
                            begin
                                k_reg     <= cnt_reg - CW'(place);
                                state_reg <= S_SUM_RD;
                            end
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_EX;
                end
                S_SCAN_EX:
                begin
                    if (kind_reg == ovl_pkg::K_ORDERED)
                    begin
                        // Insert before the first element not less than the value.
                        if ($signed(val_reg) <= $signed(mem_rdata))
                        begin
                            idx_reg   <= k_reg;
                            k_reg     <= cnt_reg - ONE;
                            state_reg <= S_UP_RD;
                        end
                        else if (last_k)
                        begin
                            state_reg <= S_PLACE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + ONE;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else if (mem_rdata == val_reg)
                    begin
                        fnd_reg <= 1'b1;
                        wh_reg  <= ovl_pkg::WHERE_W'(k_reg);
                        if (kind_reg == ovl_pkg::K_FIND)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else if (last_k)
                        begin
                            cnt_reg   <= k_reg;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            j_reg     <= k_reg;
                            k_reg     <= k_reg + ONE;
                            state_reg <= S_COMP_RD;
                        end
                    end
                    else if (last_k)
                    begin
                        st_reg    <= ovl_pkg::ST_ABSENT;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        k_reg     <= k_reg + ONE;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= S_UP_EX;
                end
                S_UP_EX:
                begin
                    // Entry k moves up one place; stop after the insert point.
                    if (k_reg == idx_reg)
                    begin
                        state_reg <= S_PLACE;
                    end
                    else
                    begin
                        k_reg     <= k_reg - ONE;
                        state_reg <= S_UP_RD;
                    end
                end
                S_PLACE:
                begin
                    cnt_reg   <= cnt_reg + ONE;
                    state_reg <= S_FINISH;
                end
                S_COMP_RD:
                begin
                    state_reg <= S_COMP_EX;
                end
                S_COMP_EX:
                begin
                    // Kept entries are packed down to the write index j.
                    if (last_k)
                    begin
                        cnt_reg   <= keep ? j_reg + ONE : j_reg;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        k_reg     <= k_reg + ONE;
                        state_reg <= S_COMP_RD;
                    end
                    if (keep)
                    begin
                        j_reg <= j_reg + ONE;
                    end
                end
                S_SUM_RD:
                begin
                    state_reg <= S_SUM_EX;
                end
                S_SUM_EX:
                begin
                    acc_reg <= acc_reg + mem_rdata;
                    if (last_k)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        k_reg     <= k_reg + ONE;
                        state_reg <= S_SUM_RD;
                    end
                end
                S_FINISH:
                begin
                    // Wait for the result register to be free.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status        <= st_reg;
                        found         <= fnd_reg;
                        where_found   <= wh_reg;
                        count         <= ovl_pkg::COUNT_W'(cnt_reg);
                        total         <= acc_reg;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The element count never passes the capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP)
        else $error("element count above capacity");

    // The store is written only while an item is in progress.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != S_IDLE))
        else $error("store written while idle");

    // An accepted beat always leaves the idle state.
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg != S_IDLE))
        else $error("accepted beat left the sequencer idle");

    // A full-store result reports a full count.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ovl_pkg::ST_FULL) |-> (count == ovl_pkg::COUNT_W'(CAP)))
        else $error("full status with room left");

endmodule

`default_nettype wire

[rtl/ordered_value_list_engine.sv]
// Ordered value list engine, top level.
// A list of up to CAPACITY signed 32-bit values held in one synchronous RAM.
// Input channel (in_valid/in_ready) carries kind, value and place; output
// channel (out_valid/out_ready) carries one result beat per input beat:
// status, found, where_found, count and total.
// One item is worked at a time. Each element the sequencer touches costs a
// read step and an execute step on the single RAM read port (address, then
// data), whether it is scanned, shifted, compacted or summed; an ordered
// insert or a removal over a nearly full list touches nearly every element.
// Clear, back insert and rejected items read no element.
// in_ready is high while the sequencer is idle; a new beat is taken even
// while the previous result waits in the output register. If the receiver
// stalls, a finished item waits until that register frees up.
// Reset clears the count and the handshake; the RAM contents are not
// cleared and only entries below the count are ever read.
// Dependencies: ovl_pkg, ovl_ram, ovl_ctrl.
`default_nettype none

module ordered_value_list_engine #(
    parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic        [ovl_pkg::KIND_W-1:0]  kind,
    input  wire logic signed [ovl_pkg::VALUE_W-1:0] value,
    input  wire logic        [ovl_pkg::PLACE_W-1:0] place,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic        [ovl_pkg::STATUS_W-1:0]     status,
    output logic                                    found,
    output logic signed [ovl_pkg::WHERE_W-1:0]      where_found,
    output logic        [ovl_pkg::COUNT_W-1:0]      count,
    output logic signed [ovl_pkg::VALUE_W-1:0]      total
);

    localparam int AW = $clog2(CAPACITY);

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [ovl_pkg::VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [ovl_pkg::VALUE_W-1:0] mem_rdata;

    // Value store.
    ovl_ram #(.CAPACITY(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer and result register.
    ovl_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .place       (place),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .where_found (where_found),
        .count       (count),
        .total       (total),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for the ordered value list engine.
// Drives list operations through the input channel, predicts each result with a
// behavioral list model and checks every result beat field by field. Uses ovl_pkg.
`timescale 1ns / 100ps

module tb;
    import ovl_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [PLACE_W-1:0]        place;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      found;
        logic [WHERE_W-1:0]        where_found;
        logic [COUNT_W-1:0]        count;
        logic [VALUE_W-1:0]        total;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [KIND_W-1:0] kind = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic [PLACE_W-1:0] place = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic found;
    logic signed [WHERE_W-1:0] where_found;
    logic [COUNT_W-1:0] count;
    logic signed [VALUE_W-1:0] total;

    op_t pending_ops[$];
    res_t expected_results[$];
    int error_count = 0;
    bit calm = 1'b0;
    int hold_off = 0;

    // Shadow copy of the list.
    logic signed [VALUE_W-1:0] list_vals[$];

    always #6 clk = ~clk;

    ordered_value_list_engine u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .value(value), .place(place),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found(found), .where_found(where_found),
        .count(count), .total(total)
    );

    // Apply one operation to the shadow list and return the predicted result.
    function automatic res_t apply_list_op(op_t op);
        res_t r;
        int idx;
        int n;
        n = list_vals.size();
        r = '{ST_OK, 1'b0, NO_INDEX, '0, '0};
        if (op.kind <= K_AT)
        begin
            if (n >= CAP)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                case (op.kind)
                    K_FRONT: idx = 0;
                    K_BACK:  idx = n;
                    K_ORDERED:
                    begin
                        idx = n;
                        for (int k = 0; k < n; k++)
                        begin
                            if (op.value <= list_vals[k])
                            begin
                                idx = k;
                                break;
                            end
                        end
                    end
                    default: idx = op.place;
                endcase
                if (idx > n)
                    r.status = ST_RANGE;
                else
                    list_vals.insert(idx, op.value);
            end
        end
        else if (op.kind <= K_FIND)
        begin
            idx = -1;
            for (int k = 0; k < n; k++)
            begin
                if (list_vals[k] == op.value)
                begin
                    idx = k;
                    break;
                end
            end
            if (idx < 0)
            begin
                r.status = ST_ABSENT;
            end
            else
            begin
                r.found = 1'b1;
                r.where_found = idx[WHERE_W-1:0];
                if (op.kind == K_RM_FIRST)
                    list_vals.delete(idx);
                else if (op.kind == K_RM_ALL)
                    list_vals = list_vals.find(x) with (x != op.value);
            end
        end
        else if (op.kind == K_CLEAR)
        begin
            list_vals.delete();
        end
        else if (op.kind == K_TAIL_SUM)
        begin
            if (op.place > n)
                r.status = ST_RANGE;
            else
                for (int k = n - op.place; k < n; k++)
                    r.total += list_vals[k];
        end
        r.count = list_vals.size();
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: offer the next pending op; prediction happens on acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(apply_list_op('{kind, value, place}));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= 6))
                begin
                    op_t op;
                    op = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    kind <= op.kind;
                    value <= op.value;
                    place <= op.place;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected beat", 0, 0);
                end
                else
                begin
                    res_t e;
                    e = expected_results.pop_front();
                    if (status !== e.status) report_mismatch("status", status, e.status);
                    if (found !== e.found) report_mismatch("found", found, e.found);
                    if (where_found !== e.where_found)
                        report_mismatch("where_found", where_found, e.where_found);
                    if (count !== e.count) report_mismatch("count", count, e.count);
                    if (total !== e.total) report_mismatch("total", total, e.total);
                end
            end
        end
    end

    // Receiver: random idling, and a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    // Values drawn from a small pool so finds and removals hit often.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(12)) - 6;
        endcase
    endfunction

    function automatic op_t random_op(int est_count);
        op_t op;
        int r;
        r = $urandom_range(99);
        op.value = pick_value();
        op.place = $urandom_range(est_count + 2);
        if (r < 55)      op.kind = $urandom_range(3);
        else if (r < 88) op.kind = $urandom_range(6, 4);
        else if (r < 90) op.kind = K_CLEAR;
        else if (r < 98) op.kind = K_TAIL_SUM;
        else             op.kind = $urandom_range(15, 9);
        if ($urandom_range(19) == 0) op.place = $urandom;
        return op;
    endfunction

    // Checked at the falling edge so the driver's updates have settled.
    task automatic wait_drained();
        while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every kind, extremes and each special case.
        pending_ops.push_back('{K_FIND, 32'sd5, 7'd0});
        pending_ops.push_back('{K_RM_FIRST, 32'sd5, 7'd0});
        pending_ops.push_back('{K_TAIL_SUM, 32'sd0, 7'd0});
        pending_ops.push_back('{K_TAIL_SUM, 32'sd0, 7'd1});
        pending_ops.push_back('{K_BACK, 32'sh7FFF_FFFF, 7'd0});
        pending_ops.push_back('{K_FRONT, 32'sh8000_0000, 7'd0});
        pending_ops.push_back('{K_ORDERED, 32'sd0, 7'd0});
        pending_ops.push_back('{K_AT, -32'sd1, 7'd3});
        pending_ops.push_back('{K_AT, 32'sd9, 7'd5});
        pending_ops.push_back('{K_AT, 32'sd9, 7'h7F});
        pending_ops.push_back('{K_TAIL_SUM, 32'sd0, 7'd2});
        pending_ops.push_back('{K_TAIL_SUM, 32'sd0, 7'd4});
        pending_ops.push_back('{K_TAIL_SUM, 32'sd0, 7'd5});
        pending_ops.push_back('{K_BACK, 32'sd0, 7'd0});
        pending_ops.push_back('{K_FIND, 32'sd0, 7'd0});
        pending_ops.push_back('{K_RM_ALL, 32'sd0, 7'd0});
        pending_ops.push_back('{K_RM_FIRST, -32'sd1, 7'd0});
        pending_ops.push_back('{4'd9, 32'sd1, 7'd1});
        pending_ops.push_back('{4'd15, -32'sd1, 7'h7F});
        pending_ops.push_back('{K_CLEAR, 32'sd0, 7'd0});
        // Fill the store, overflow it, then sum the whole list.
        for (int i = 0; i < CAP + 2; i++)
            pending_ops.push_back('{K_BACK, $urandom, 7'd0});
        pending_ops.push_back('{K_ORDERED, 32'sd0, 7'd0});
        pending_ops.push_back('{K_AT, 32'sd0, 7'd0});
        pending_ops.push_back('{K_TAIL_SUM, 32'sd0, 7'd64});
        pending_ops.push_back('{K_CLEAR, 32'sd0, 7'd0});
        wait_drained();

        // A long receiver hold-off while the sender keeps going.
        hold_off = 200;
        for (int i = 0; i < 30; i++)
            pending_ops.push_back(random_op(10));
        wait_drained();

        // Random traffic with a stretch of no idling.
        for (int i = 0; i < 400; i++)
        begin
            if (i == 200)
            begin
                wait_drained();
                calm = 1'b1;
            end
            if (i == 320)
            begin
                wait_drained();
                calm = 1'b0;
            end
            pending_ops.push_back(random_op(list_vals.size()));
            while (pending_ops.size() > 4) @(posedge clk);
        end
        wait_drained();
        repeat (600) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[files.f]
rtl/ovl_pkg.sv
rtl/ovl_ram.sv
rtl/ovl_ctrl.sv
rtl/ordered_value_list_engine.sv
verif/tb.sv
